FILE: rtl/lltl_pkg.sv
// shared kinds, lexer modes and byte-class helpers for the token lexer
package lltl_pkg;

  localparam int KIND_W = 5;

  // token kinds as seen on the output word
  typedef enum logic [KIND_W-1:0] {
    K_ERROR   = 5'd0,
    K_EOF     = 5'd1,
    K_DEFINE  = 5'd2,
    K_LAMBDA  = 5'd3,
    K_IF      = 5'd4,
    K_OPEN    = 5'd5,
    K_CLOSE   = 5'd6,
    K_ADD     = 5'd7,
    K_SUB     = 5'd8,
    K_MUL     = 5'd9,
    K_DIV     = 5'd10,
    K_GT      = 5'd11,
    K_LT      = 5'd12,
    K_EQ      = 5'd13,
    K_SYMBOL  = 5'd14,
    K_INTEGER = 5'd15,
    K_SPACE   = 5'd16,
    K_NEWLINE = 5'd17
  } kind_t;

  // lexer mode, one-hot
  typedef enum logic [5:0] {
    M_IDLE  = 6'b000001,
    M_SPACE = 6'b000010,
    M_IDENT = 6'b000100,
    M_SIGN  = 6'b001000,
    M_INT   = 6'b010000,
    M_ERROR = 6'b100000
  } mode_t;

  // keyword match bits
  localparam int KW_DEFINE_BIT = 0;
  localparam int KW_LAMBDA_BIT = 1;
  localparam int KW_IF_BIT     = 2;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_VT  = 8'h0b;
  localparam logic [7:0] CH_FF  = 8'h0c;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_SP  = 8'h20;

  function automatic logic is_ws(input logic [7:0] c);
    return c == CH_TAB || c == CH_SP || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return is_ws(c) || c == CH_LF || c == ")" || c == CH_NUL;
  endfunction

  function automatic logic is_idc(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "!" || c == "-" || c == "?";
  endfunction

  // which keywords still agree with byte c at position idx
  function automatic logic [2:0] kw_bits(input logic [2:0] idx, input logic [7:0] c);
    logic [2:0] b;
    b = 3'b000;
    case (idx)
      3'd0: begin
        b[KW_DEFINE_BIT] = (c == "d");
        b[KW_LAMBDA_BIT] = (c == "l");
        b[KW_IF_BIT]     = (c == "i");
      end
      3'd1: begin
        b[KW_DEFINE_BIT] = (c == "e");
        b[KW_LAMBDA_BIT] = (c == "a");
        b[KW_IF_BIT]     = (c == "f");
      end
      3'd2: begin
        b[KW_DEFINE_BIT] = (c == "f");
        b[KW_LAMBDA_BIT] = (c == "m");
      end
      3'd3: begin
        b[KW_DEFINE_BIT] = (c == "i");
        b[KW_LAMBDA_BIT] = (c == "b");
      end
      3'd4: begin
        b[KW_DEFINE_BIT] = (c == "n");
        b[KW_LAMBDA_BIT] = (c == "d");
      end
      3'd5: begin
        b[KW_DEFINE_BIT] = (c == "e");
        b[KW_LAMBDA_BIT] = (c == "a");
      end
      default: b = 3'b000;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/lltl_core.sv
// lexer state and per-byte token decision, up to two tokens per byte
module lltl_core #(
  parameter int LEN_WIDTH = 8,
  parameter int POS_WIDTH = 16,
  parameter int TOK_W     = lltl_pkg::KIND_W + LEN_WIDTH + POS_WIDTH + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       ch,
  output logic [1:0]       tok_cnt,
  output logic [TOK_W-1:0] tok0,   // kind, length, start, last from the lowest bit up
  output logic [TOK_W-1:0] tok1
);
  import lltl_pkg::*;

  localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};
  localparam logic [LEN_WIDTH-1:0] LEN_ONE = LEN_WIDTH'(1);
  localparam logic [LEN_WIDTH-1:0] LEN_TWO = LEN_WIDTH'(2);
  localparam logic [LEN_WIDTH-1:0] LEN_SIX = LEN_WIDTH'(6);

  mode_t                mode, mode_next;
  logic                 sign_is_minus, sign_is_minus_next;
  logic [2:0]           keyword_match, keyword_match_next;
  logic [LEN_WIDTH-1:0] run_length, run_length_next;
  logic [POS_WIDTH-1:0] run_start, run_start_next;
  logic [POS_WIDTH-1:0] byte_position, byte_position_next;

  logic                 absorbed;
  logic                 emit_a, emit_b, single_hit;
  kind_t                kind_a, kind_b, single_kind;
  logic [LEN_WIDTH-1:0] len_a, len_b, len_grow;
  logic [POS_WIDTH-1:0] start_a;

  // saturating run growth
  assign len_grow = (run_length == LEN_MAX) ? run_length : run_length + LEN_ONE;

  // single-byte tokens
  always_comb begin
    single_hit  = 1'b1;
    single_kind = K_ERROR;
    case (ch)
      CH_LF:   single_kind = K_NEWLINE;
      "(":     single_kind = K_OPEN;
      ")":     single_kind = K_CLOSE;
      "*":     single_kind = K_MUL;
      "/":     single_kind = K_DIV;
      ">":     single_kind = K_GT;
      "<":     single_kind = K_LT;
      "=":     single_kind = K_EQ;
      default: single_hit  = 1'b0;
    endcase
  end

  // close the pending token, then dispatch the byte itself
  always_comb begin
    mode_next          = mode;
    sign_is_minus_next = sign_is_minus;
    keyword_match_next = keyword_match;
    run_length_next    = run_length;
    run_start_next     = run_start;
    absorbed           = 1'b0;
    emit_a             = 1'b0;
    kind_a             = K_ERROR;
    len_a              = '0;
    start_a            = run_start;
    emit_b             = 1'b0;
    kind_b             = K_ERROR;
    len_b              = '0;

    unique case (mode)
      M_ERROR: begin
        absorbed = 1'b1;
        if (ch == CH_NUL) mode_next = M_IDLE;
      end
      M_SPACE: begin
        if (is_ws(ch)) begin
          run_length_next = len_grow;
          absorbed        = 1'b1;
        end else begin
          emit_a = 1'b1;
          kind_a = K_SPACE;
          len_a  = run_length;
        end
      end
      M_IDENT: begin
        if (is_idc(ch)) begin
          keyword_match_next = keyword_match &
              ((run_length < LEN_SIX) ? kw_bits(run_length[2:0], ch) : 3'b000);
          run_length_next    = len_grow;
          absorbed           = 1'b1;
        end else begin
          emit_a = 1'b1;
          len_a  = run_length;
          if (run_length == LEN_SIX && keyword_match[KW_DEFINE_BIT]) kind_a = K_DEFINE;
          else if (run_length == LEN_SIX && keyword_match[KW_LAMBDA_BIT]) kind_a = K_LAMBDA;
          else if (run_length == LEN_TWO && keyword_match[KW_IF_BIT]) kind_a = K_IF;
          else kind_a = K_SYMBOL;
        end
      end
      M_SIGN, M_INT: begin
        if (is_digit(ch)) begin
          mode_next       = M_INT;
          run_length_next = len_grow;
          absorbed        = 1'b1;
        end else if (is_delim(ch)) begin
          emit_a = 1'b1;
          len_a  = run_length;
          if (mode == M_SIGN) kind_a = sign_is_minus ? K_SUB : K_ADD;
          else kind_a = K_INTEGER;
        end else begin
          // integer or sign glued to a foreign byte
          emit_a    = 1'b1;
          kind_a    = K_ERROR;
          mode_next = M_ERROR;
          absorbed  = 1'b1;
        end
      end
      M_IDLE: begin
      end
      default: begin
      end
    endcase

    if (!absorbed) begin
      mode_next = M_IDLE;
      if (ch == CH_NUL) begin
        emit_b = 1'b1;
        kind_b = K_EOF;
      end else if (single_hit) begin
        emit_b = 1'b1;
        kind_b = single_kind;
        len_b  = LEN_ONE;
      end else if (is_ws(ch)) begin
        mode_next       = M_SPACE;
        run_start_next  = byte_position;
        run_length_next = LEN_ONE;
      end else if (ch == "+" || ch == "-") begin
        mode_next          = M_SIGN;
        run_start_next     = byte_position;
        run_length_next    = LEN_ONE;
        sign_is_minus_next = (ch == "-");
      end else if (is_digit(ch)) begin
        mode_next       = M_INT;
        run_start_next  = byte_position;
        run_length_next = LEN_ONE;
      end else if (is_alpha(ch)) begin
        mode_next          = M_IDENT;
        run_start_next     = byte_position;
        run_length_next    = LEN_ONE;
        keyword_match_next = kw_bits(3'd0, ch);
      end else begin
        emit_b    = 1'b1;
        kind_b    = K_ERROR;
        mode_next = M_ERROR;
      end
    end

    // offset restarts after end of stream
    if (ch == CH_NUL && mode_next == M_IDLE) byte_position_next = '0;
    else byte_position_next = byte_position + POS_WIDTH'(1);
  end

  // pack tokens, first emitted in slot zero
  always_comb begin
    tok_cnt = {1'b0, emit_a} + {1'b0, emit_b};
    tok1    = {1'b1, byte_position, len_b, kind_b};
    if (emit_a) tok0 = {~emit_b, start_a, len_a, kind_a};
    else tok0 = tok1;
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      sign_is_minus <= 1'b0;
      keyword_match <= 3'b111;
      run_length    <= '0;
      run_start     <= '0;
      byte_position <= '0;
    end else if (step) begin
      mode          <= mode_next;
      sign_is_minus <= sign_is_minus_next;
      keyword_match <= keyword_match_next;
      run_length    <= run_length_next;
      run_start     <= run_start_next;
      byte_position <= byte_position_next;
    end
  end

endmodule

FILE: rtl/lltl_outq.sv
// four-entry token queue, takes up to two tokens per cycle, gives one
module lltl_outq #(
  parameter int TOK_W = 30
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_cnt,
  input  logic [TOK_W-1:0] push0,
  input  logic [TOK_W-1:0] push1,
  output logic             room,
  output logic             head_valid,
  input  logic             head_take,
  output logic [TOK_W-1:0] head
);
  import lltl_pkg::*;

  logic [TOK_W-1:0] slots [4];
  logic [1:0]       wr_ptr, rd_ptr;
  logic [2:0]       count;
  logic             pop;

  assign head_valid = (count != 3'd0);
  assign pop        = head_valid && head_take;
  assign room       = (count <= 3'd2);
  assign head       = slots[rd_ptr];

  // token storage
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) slots[wr_ptr] <= push0;
    if (push_cnt == 2'd2) slots[wr_ptr + 2'd1] <= push1;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, push_cnt} - {2'b00, pop};
    end
  end

endmodule

FILE: rtl/lisp_token_lexer_top.sv
// top level of the streaming lexer: input register, lexer core, token queue
//
// Source bytes enter on the s_axis channel, one byte per word; a zero byte
// ends the stream. Tokens leave on the m_axis channel as kind, length and
// start offset, with tlast high on the final token caused by one input byte.
// A byte that closes a pending token and forms a token of its own gives two
// words; every other byte gives zero or one.
// An accepted byte waits in the input register until the queue has room,
// is then lexed, and its tokens are written to the queue that drives m_axis.
// Throughput: one byte per cycle while the queue has room for two tokens;
// the output side delivers one token per cycle, so two-token bytes in a
// row are limited by the output port.
// The receiver may stall at any time; tokens wait in a four-entry queue and
// s_axis_tready falls once a byte waits and the queue cannot take two more.
// Reset (rst, synchronous) empties the queue and input register, returns
// the lexer to idle and sets the stream offset to zero.
module lisp_token_lexer_top #(
  parameter int LEN_WIDTH = 8,
  parameter int POS_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // ch
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // token_kind, token_length, token_start, zero fill
  output logic [((lltl_pkg::KIND_W + LEN_WIDTH + POS_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic m_axis_tlast
);
  import lltl_pkg::*;

  localparam int FIELD_W = KIND_W + LEN_WIDTH + POS_WIDTH;
  localparam int DATA_W  = ((FIELD_W + 7) / 8) * 8;
  localparam int TOK_W   = FIELD_W + 1;

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             step;
  logic             room;
  logic [1:0]       tok_cnt;
  logic [1:0]       push_cnt;
  logic [TOK_W-1:0] tok0, tok1, head;

  assign step          = in_valid && room;
  assign s_axis_tready = !in_valid || step;

  // tokens enter the queue only when the byte is lexed
  assign push_cnt = step ? tok_cnt : 2'd0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) in_byte <= s_axis_tdata;
  end

  lltl_core #(
    .LEN_WIDTH(LEN_WIDTH),
    .POS_WIDTH(POS_WIDTH),
    .TOK_W    (TOK_W)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .ch     (in_byte),
    .tok_cnt(tok_cnt),
    .tok0   (tok0),
    .tok1   (tok1)
  );

  lltl_outq #(
    .TOK_W(TOK_W)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push0     (tok0),
    .push1     (tok1),
    .room      (room),
    .head_valid(m_axis_tvalid),
    .head_take (m_axis_tready),
    .head      (head)
  );

  // output word
  assign m_axis_tdata = DATA_W'(head[FIELD_W-1:0]);
  assign m_axis_tlast = head[TOK_W-1];

endmodule
